FILE: hw/rtl/msps_pkg.sv
`default_nettype none

package msps_pkg;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_MOVE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic [3:0]         stack_id;
		logic [3:0]         source_stack;
		logic signed [31:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pop_value;
		logic [1:0]         status;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic push_wr;
		logic move_wr;
		logic node_rd;
		logic pop_wb;
		logic emit_full;
		logic emit_empty;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] func;
		logic       dst_ok;
		logic       src_ok;
		logic       same_stack;
		logic       ne_dst;
		logic       ne_src;
		logic       full;
		logic       out_free;
	} stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/msps_ctrl.sv
`default_nettype none

module msps_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire msps_pkg::stat_t st,
	output msps_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP_WB
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (st.func)
					msps_pkg::OP_PUSH: begin
						if (!st.dst_ok) begin
							state_nxt = S_IDLE;
						end else if (st.full) begin
							// result has to wait for room in the output register
							if (st.out_free) begin
								cmd.emit_full = 1'b1;
								state_nxt = S_IDLE;
							end
						end else begin
							cmd.push_wr = 1'b1;
							state_nxt = S_IDLE;
						end
					end
					msps_pkg::OP_POP: begin
						if (!st.dst_ok || !st.ne_dst) begin
							if (st.out_free) begin
								cmd.emit_empty = 1'b1;
								state_nxt = S_IDLE;
							end
						end else begin
							cmd.node_rd = 1'b1;
							state_nxt = S_POP_WB;
						end
					end
					msps_pkg::OP_MOVE: begin
						if (st.dst_ok && st.src_ok && !st.same_stack && st.ne_src) begin
							cmd.move_wr = 1'b1;
						end
						state_nxt = S_IDLE;
					end
					default: begin
						state_nxt = S_IDLE;
					end
				endcase
			end
			S_POP_WB: begin
				if (st.out_free) begin
					cmd.pop_wb = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/msps_dpath.sv
`default_nettype none

module msps_dpath #(
	parameter int NUM_STACKS = 16,
	parameter int POOL_DEPTH = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire msps_pkg::cmd_t     cmd,
	output msps_pkg::stat_t         st,
	input  wire msps_pkg::in_item_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output msps_pkg::out_item_t     out_data
);

	localparam int AW = $clog2(POOL_DEPTH);
	localparam int PW = $clog2(POOL_DEPTH + 1);
	localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam logic [PW-1:0] NIL = PW'(POOL_DEPTH);

	msps_pkg::in_item_t item_q;

	logic [NUM_STACKS-1:0] ne_q;
	logic [PW-1:0]         free_head_q;
	logic [PW-1:0]         hwm_q;

	logic [AW-1:0] top_mem [NUM_STACKS];
	logic [AW-1:0] bot_mem [NUM_STACKS];
	logic [PW-1:0] link_mem [POOL_DEPTH];
	logic [31:0]   val_mem [POOL_DEPTH];

	logic [AW-1:0] top_dst_q;
	logic [AW-1:0] top_src_q;
	logic [AW-1:0] bot_src_q;
	logic [PW-1:0] link_rd_q;
	logic [31:0]   val_rd_q;

	logic                out_valid_q;
	msps_pkg::out_item_t out_q;

	logic [SW-1:0] dst_idx;
	logic [SW-1:0] src_idx;
	logic          dst_ok;
	logic          src_ok;
	logic          ne_dst;
	logic          ne_src;
	logic [AW-1:0] alloc_node;
	logic          fresh;
	logic [PW-1:0] next_free;
	logic [AW-1:0] node_addr;
	logic [PW-1:0] link_below;

	logic          link_we;
	logic [AW-1:0] link_wa;
	logic [PW-1:0] link_wd;
	logic          top_we;
	logic [AW-1:0] top_wd;
	logic          bot_we;
	logic [AW-1:0] bot_wd;

	assign dst_idx = SW'(item_q.stack_id);
	assign src_idx = SW'(item_q.source_stack);
	assign dst_ok  = 32'(item_q.stack_id) < NUM_STACKS;
	assign src_ok  = 32'(item_q.source_stack) < NUM_STACKS;
	assign ne_dst  = dst_ok && ne_q[dst_idx];
	assign ne_src  = src_ok && ne_q[src_idx];

	// nodes at or above the high-water mark were never handed out and
	// still form the initial chain, so their link is their index plus one
	assign alloc_node = free_head_q[AW-1:0];
	assign fresh      = (free_head_q == hwm_q);
	assign next_free  = fresh ? (free_head_q + PW'(1)) : link_rd_q;
	assign link_below = ne_dst ? PW'(top_dst_q) : NIL;
	assign node_addr  = cmd.node_rd ? top_dst_q : alloc_node;

	assign st.func       = item_q.func;
	assign st.dst_ok     = dst_ok;
	assign st.src_ok     = src_ok;
	assign st.same_stack = (item_q.stack_id == item_q.source_stack);
	assign st.ne_dst     = ne_dst;
	assign st.ne_src     = ne_src;
	assign st.full       = (free_head_q == NIL);
	assign st.out_free   = !out_valid_q || out_ready;

	always_comb begin
		link_we = 1'b0;
		link_wa = alloc_node;
		link_wd = link_below;
		top_we  = 1'b0;
		top_wd  = alloc_node;
		bot_we  = 1'b0;
		bot_wd  = alloc_node;
		if (cmd.push_wr) begin
			link_we = 1'b1;
			top_we  = 1'b1;
			bot_we  = !ne_dst;
		end
		if (cmd.move_wr) begin
			link_we = 1'b1;
			link_wa = bot_src_q;
			top_we  = 1'b1;
			top_wd  = top_src_q;
			bot_we  = !ne_dst;
			bot_wd  = bot_src_q;
		end
		if (cmd.pop_wb) begin
			link_we = 1'b1;
			link_wa = top_dst_q;
			link_wd = free_head_q;
			top_we  = 1'b1;
			top_wd  = link_rd_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q    <= in_data;
			top_dst_q <= top_mem[SW'(in_data.stack_id)];
			top_src_q <= top_mem[SW'(in_data.source_stack)];
			bot_src_q <= bot_mem[SW'(in_data.source_stack)];
		end
		if (cmd.accept || cmd.node_rd) begin
			link_rd_q <= link_mem[node_addr];
		end
		if (cmd.node_rd) begin
			val_rd_q <= val_mem[node_addr];
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (cmd.push_wr) begin
			val_mem[alloc_node] <= item_q.push_value;
		end
		if (top_we) begin
			top_mem[dst_idx] <= top_wd;
		end
		if (bot_we) begin
			bot_mem[dst_idx] <= bot_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q        <= '0;
			free_head_q <= '0;
			hwm_q       <= '0;
		end else begin
			if (cmd.push_wr) begin
				ne_q[dst_idx] <= 1'b1;
				free_head_q   <= next_free;
				if (fresh) begin
					hwm_q <= hwm_q + PW'(1);
				end
			end
			if (cmd.move_wr) begin
				ne_q[dst_idx] <= 1'b1;
				ne_q[src_idx] <= 1'b0;
			end
			if (cmd.pop_wb) begin
				if (link_rd_q == NIL) begin
					ne_q[dst_idx] <= 1'b0;
				end
				free_head_q <= PW'(top_dst_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_full || cmd.emit_empty || cmd.pop_wb) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_full) begin
			out_q.pop_value <= '0;
			out_q.status    <= msps_pkg::ST_FULL;
		end else if (cmd.emit_empty) begin
			out_q.pop_value <= '0;
			out_q.status    <= msps_pkg::ST_EMPTY;
		end else if (cmd.pop_wb) begin
			out_q.pop_value <= val_rd_q;
			out_q.status    <= msps_pkg::ST_OK;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/multi_stack_pool_with_splice_core.sv
// Several LIFO stacks sharing one node pool with a free list.
// Input channel in_valid/in_ready/in_data carries one operation per item:
// push a value, pop a top, or splice a whole source stack onto a destination.
// Output channel out_valid/out_ready/out_data carries a result only for a
// pop (value or empty) and for a push dropped because the pool is full.
// After an item is accepted, the stack pointers are read into registers;
// push and move then write their pointers in the cycle after acceptance.
// An empty pop or full push puts its result into the output register from
// the execute state; a real pop first does a registered read of the node
// memory there, then puts the value out from a write-back state. No new
// item is taken before the current one is finished.
// Reset leaves every stack empty and the whole pool free. No clearing pass
// runs: a high-water mark stands for the untouched part of the free chain.
// The result sits in an output register; new items keep being accepted while
// it waits, and only an operation that produces a result holds (and stops
// taking items) until that register has been taken.
`default_nettype none

module multi_stack_pool_with_splice_core #(
	parameter int NUM_STACKS = 16,
	parameter int POOL_DEPTH = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire msps_pkg::in_item_t in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output msps_pkg::out_item_t     out_data
);

	msps_pkg::cmd_t  cmd;
	msps_pkg::stat_t st;

	msps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	msps_dpath #(
		.NUM_STACKS (NUM_STACKS),
		.POOL_DEPTH (POOL_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/msps_checker.sv
`default_nettype none

module msps_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire msps_pkg::in_item_t  in_data,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire msps_pkg::out_item_t out_data
);

	// every accepted item keeps the block busy, so input ready drops after an acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted item");

	// a new result is only produced from a busy cycle
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without work in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == msps_pkg::ST_OK ||
			out_data.status == msps_pkg::ST_EMPTY ||
			out_data.status == msps_pkg::ST_FULL))
		else $error("unknown status code");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != msps_pkg::ST_OK |-> out_data.pop_value == 32'sd0)
		else $error("nonzero value with failing status");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result dropped or changed");

endmodule

bind multi_stack_pool_with_splice_core msps_checker u_msps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

FILE: bench/multi_stack_pool_with_splice_core_test.sv
`default_nettype none

module multi_stack_pool_with_splice_core_test;

	localparam int NUM_STACKS = 16;
	localparam int POOL_DEPTH = 1024;
	localparam int PTR_W = 11;
	localparam logic [PTR_W-1:0] NULL_NODE = PTR_W'(POOL_DEPTH);
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 8;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	msps_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	msps_pkg::out_item_t out_data;

	int idle_cycles = 0;
	int burst_left = 0;
	bit hold_request = 1'b0;

	class stack_pool_scoreboard;
		logic [PTR_W-1:0]    top_node [NUM_STACKS];
		logic [PTR_W-1:0]    bottom_node [NUM_STACKS];
		logic [31:0]         node_val [POOL_DEPTH];
		logic [PTR_W-1:0]    node_next [POOL_DEPTH];
		logic [PTR_W-1:0]    free_node;
		msps_pkg::out_item_t pending [$];
		int                  errors;

		function new();
			for (int i = 0; i < NUM_STACKS; i++) begin
				top_node[i] = NULL_NODE;
				bottom_node[i] = NULL_NODE;
			end
			for (int i = 0; i < POOL_DEPTH; i++) begin
				node_val[i] = '0;
				node_next[i] = PTR_W'(i + 1);
			end
			free_node = '0;
			errors = 0;
		endfunction

		// update the stacks for one accepted item and queue any result it causes
		function void note_input(msps_pkg::in_item_t it);
			logic [PTR_W-1:0] n;
			int d;
			int s;
			msps_pkg::out_item_t r;
			d = it.stack_id;
			s = it.source_stack;
			r.pop_value = '0;
			r.status = msps_pkg::ST_OK;
			case (it.func)
				msps_pkg::OP_PUSH: begin
					if (free_node == NULL_NODE) begin
						r.status = msps_pkg::ST_FULL;
						pending.push_back(r);
					end else begin
						n = free_node;
						free_node = node_next[n];
						node_val[n] = it.push_value;
						node_next[n] = top_node[d];
						if (top_node[d] == NULL_NODE)
							bottom_node[d] = n;
						top_node[d] = n;
					end
				end
				msps_pkg::OP_POP: begin
					if (top_node[d] == NULL_NODE) begin
						r.status = msps_pkg::ST_EMPTY;
					end else begin
						n = top_node[d];
						top_node[d] = node_next[n];
						if (top_node[d] == NULL_NODE)
							bottom_node[d] = NULL_NODE;
						node_next[n] = free_node;
						free_node = n;
						r.pop_value = node_val[n];
					end
					pending.push_back(r);
				end
				msps_pkg::OP_MOVE: begin
					// splice: source bottom links onto destination top
					if (s != d && top_node[s] != NULL_NODE) begin
						node_next[bottom_node[s]] = top_node[d];
						if (top_node[d] == NULL_NODE)
							bottom_node[d] = bottom_node[s];
						top_node[d] = top_node[s];
						top_node[s] = NULL_NODE;
						bottom_node[s] = NULL_NODE;
					end
				end
				default: begin
				end
			endcase
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		task check_result(msps_pkg::out_item_t got);
			msps_pkg::out_item_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result value %0d status %0d",
					got.pop_value, got.status));
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.pop_value !== want.pop_value)
				report_mismatch($sformatf("pop_value %0d, expected %0d",
					got.pop_value, want.pop_value));
		endtask
	endclass

	stack_pool_scoreboard sb = new();

	multi_stack_pool_with_splice_core #(
		.NUM_STACKS(NUM_STACKS),
		.POOL_DEPTH(POOL_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[multi_stack_pool_with_splice_core] ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic msps_pkg::in_item_t make_item(logic [1:0] f, int dst, int src,
		logic [31:0] v);
		msps_pkg::in_item_t it;
		it.func = f;
		it.stack_id = 4'(dst);
		it.source_stack = 4'(src);
		it.push_value = v;
		return it;
	endfunction

	// mostly a few busy stacks so that moves and pops find something
	function automatic int pick_stack();
		if ($urandom_range(0, 9) < 7)
			return $urandom_range(0, 3);
		return $urandom_range(0, NUM_STACKS - 1);
	endfunction

	task automatic send_item(msps_pkg::in_item_t it);
		int gap;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		gap = pick_gap();
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_ops(int count);
		int r;
		msps_pkg::in_item_t it;
		for (int k = 0; k < count; k++) begin
			if (k % 80 == 40)
				burst_left = $urandom_range(10, 40);
			r = $urandom_range(0, 99);
			it = make_item(msps_pkg::OP_PUSH, pick_stack(), pick_stack(), $urandom());
			if (r < 45)
				it.func = msps_pkg::OP_PUSH;
			else if (r < 80)
				it.func = msps_pkg::OP_POP;
			else if (r < 95)
				it.func = msps_pkg::OP_MOVE;
			else
				it.func = OP_UNUSED;
			send_item(it);
		end
	endtask

	initial begin : receiver
		int n;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				// long hold so the output register stays full and the input backs up
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 19) == 0) begin
				out_ready <= 1'b1;
				repeat (50) @(posedge clk);
			end else begin
				n = pick_gap();
				if (n == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
					out_ready <= 1'b1;
				end
			end
		end
	end

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(make_item(msps_pkg::OP_POP, 0, 0, '0));
		send_item(make_item(msps_pkg::OP_PUSH, 0, 0, 32'h7fff_ffff));
		send_item(make_item(msps_pkg::OP_PUSH, 0, 15, 32'h8000_0000));
		send_item(make_item(msps_pkg::OP_PUSH, 15, 0, 32'hffff_ffff));
		send_item(make_item(msps_pkg::OP_PUSH, 15, 15, 32'h0000_0000));
		send_item(make_item(msps_pkg::OP_MOVE, 0, 15, 32'hffff_ffff));
		send_item(make_item(msps_pkg::OP_MOVE, 0, 0, '0));
		send_item(make_item(msps_pkg::OP_MOVE, 3, 5, '0));
		send_item(make_item(msps_pkg::OP_MOVE, 7, 0, '0));
		send_item(make_item(OP_UNUSED, 15, 15, 32'hffff_ffff));
		repeat (5)
			send_item(make_item(msps_pkg::OP_POP, 7, 0, '0));
		send_item(make_item(msps_pkg::OP_POP, 15, 15, '0));
		send_item(make_item(msps_pkg::OP_PUSH, 3, 0, 32'h0000_0001));
		send_item(make_item(msps_pkg::OP_PUSH, 9, 0, 32'h5555_aaaa));
		send_item(make_item(msps_pkg::OP_MOVE, 9, 3, '0));
		send_item(make_item(msps_pkg::OP_POP, 9, 0, '0));
		send_item(make_item(msps_pkg::OP_POP, 9, 0, '0));
		send_item(make_item(msps_pkg::OP_POP, 3, 0, '0));
		send_item(make_item(msps_pkg::OP_POP, 0, 0, '0));

		random_ops(120);
		hold_request = 1'b1;
		random_ops(130);
		random_ops(280);

		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("[multi_stack_pool_with_splice_core] OK");
		else
			$display("[multi_stack_pool_with_splice_core] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
